// ----- rtl/fmarc_pkg.sv -----
// Shared types, codes and helper functions for the first-match access rule checker.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package fmarc_pkg;

  // Request kinds.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_CHECK = 2'd1,
    OP_AUDIT = 2'd2
  } op_e;

  // Rule source kinds.
  typedef enum logic [1:0] {
    SRC_PREFIX   = 2'd0,
    SRC_LOOPBACK = 2'd1,
    SRC_ANY_CERT = 2'd2,
    SRC_NAMED    = 2'd3
  } src_e;

  // Control states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_HOLD = 2'd2
  } state_e;

  // Transport codes; the unused code behaves like "any".
  localparam logic [1:0] TR_ANY   = 2'd0;
  localparam logic [1:0] TR_PLAIN = 2'd1;
  localparam logic [1:0] TR_ENC   = 2'd2;

  localparam int unsigned CAP_ADMIN_BIT = 3;
  localparam logic [7:0]  LOOPBACK_V4   = 8'd127;
  localparam logic [7:0]  WIDE_V4       = 8'd24;
  localparam logic [7:0]  WIDE_V6       = 8'd120;
  localparam logic [7:0]  PLEN_MAX_V4   = 8'd32;
  localparam logic [7:0]  PLEN_MAX_V6   = 8'd128;
  localparam logic [7:0]  HALF_BITS     = 8'd64;
  localparam logic [4:0]  COUNT_SAT     = 5'd31;

  // One stored rule, without its certificate tag.
  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    src_e        kind;
    logic        v6;
    logic [7:0]  plen;
    logic [1:0]  trans;
    logic [3:0]  caps;
    logic        force_ack;
  } rule_t;

  // Fields of a check request that the evaluator needs.
  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        v6;
    logic [3:0]  need;
    logic        enc;
    logic        ver;
  } req_t;

  // Verdict on one rule.
  typedef struct packed {
    logic hit;
    logic grant;
    logic offend;
    logic any_cert;
  } verdict_t;

  // Mask with the top n bits of a 64-bit word set.
  function automatic logic [63:0] top_mask(input logic [7:0] n);
    logic [63:0] m;
    if (n == 8'd0) begin
      m = '0;
    end else if (n >= HALF_BITS) begin
      m = '1;
    end else begin
      m = 64'hFFFF_FFFF_FFFF_FFFF << (7'd64 - n[6:0]);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/fmarc_rule_mem.sv -----
// Rule table storage: one write port and one registered read port.
// Depends on fmarc_pkg for the rule record type.
`default_nettype none

module fmarc_rule_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = 4,
  parameter int unsigned TAG_W = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 wr_en_i,
  input  wire logic [IDX_W-1:0]     wr_addr_i,
  input  wire fmarc_pkg::rule_t     wr_rule_i,
  input  wire logic [TAG_W-1:0]     wr_tag_i,
  input  wire logic                 rd_en_i,
  input  wire logic [IDX_W-1:0]     rd_addr_i,
  output fmarc_pkg::rule_t          rd_rule_o,
  output logic [TAG_W-1:0]          rd_tag_o
);
  import fmarc_pkg::*;

  rule_t            rule_mem [DEPTH];
  logic [TAG_W-1:0] tag_mem  [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rule_mem[wr_addr_i] <= wr_rule_i;
      tag_mem[wr_addr_i]  <= wr_tag_i;
    end
  end

  // Read port, registered: the data appears in the cycle after the read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_rule_o <= rule_mem[rd_addr_i];
      rd_tag_o  <= tag_mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fmarc_rule_eval.sv -----
// Evaluates one stored rule against the current request: match, grant and audit verdict.
// Depends on fmarc_pkg for the rule, request and verdict types.
`default_nettype none

module fmarc_rule_eval #(
  parameter int unsigned TAG_W = 16
) (
  input  wire fmarc_pkg::rule_t     rule_i,
  input  wire logic [TAG_W-1:0]     rule_tag_i,
  input  wire fmarc_pkg::req_t      req_i,
  input  wire logic [TAG_W-1:0]     req_tag_i,
  output fmarc_pkg::verdict_t       verdict_o
);
  import fmarc_pkg::*;

  logic [63:0] hi_mask;
  logic [63:0] lo_mask;
  logic        prefix_hit;
  logic        loop_hit;
  logic        src_hit;
  logic        blocked;
  logic        broad;

  // Prefix comparison over both address halves.
  always_comb begin
    hi_mask = top_mask(rule_i.plen);
    lo_mask = (rule_i.plen > HALF_BITS) ? top_mask(rule_i.plen - HALF_BITS) : '0;
    prefix_hit = (rule_i.v6 == req_i.v6) &&
                 (((rule_i.hi ^ req_i.hi) & hi_mask) == '0) &&
                 (((rule_i.lo ^ req_i.lo) & lo_mask) == '0);
    loop_hit = req_i.v6 ? ((req_i.hi == 64'd0) && (req_i.lo == 64'd1))
                        : (req_i.hi[63:56] == LOOPBACK_V4);
  end

  // Source decode.
  always_comb begin
    unique case (rule_i.kind)
      SRC_PREFIX:   src_hit = prefix_hit;
      SRC_LOOPBACK: src_hit = loop_hit;
      SRC_ANY_CERT: src_hit = req_i.ver;
      SRC_NAMED:    src_hit = req_i.ver && (req_tag_i != '0) && (rule_tag_i != '0) &&
                              (rule_tag_i == req_tag_i);
      default:      src_hit = 1'b0;
    endcase
  end

  // Transport filter, grant and audit verdict.
  always_comb begin
    blocked = ((rule_i.trans == TR_PLAIN) && req_i.enc) ||
              ((rule_i.trans == TR_ENC) && !req_i.enc);
    broad   = (rule_i.kind == SRC_ANY_CERT) ||
              ((rule_i.kind == SRC_PREFIX) &&
               (rule_i.plen < (rule_i.v6 ? WIDE_V6 : WIDE_V4)));
    verdict_o.hit      = !blocked && src_hit;
    verdict_o.grant    = |(rule_i.caps & req_i.need);
    verdict_o.offend   = rule_i.caps[CAP_ADMIN_BIT] && !rule_i.force_ack && broad;
    verdict_o.any_cert = (rule_i.kind == SRC_ANY_CERT);
  end

endmodule

`default_nettype wire

// ----- rtl/first_match_access_rule_check_top.sv -----
// Top level of the first-match access rule checker: control, request latch and result queue.
// Depends on fmarc_pkg, fmarc_rule_mem and fmarc_rule_eval.
//
// The block holds an ordered table of MAX_RULES access rules in a synchronous memory
// and answers one result per request. A write request stores a rule and answers
// without a walk. A check or audit request walks the active rules (rules_in_use,
// capped at MAX_RULES) through the single read port of the table, one rule per
// cycle. A check stops early at its first matching rule. One request is in work
// at a time; a finished result waits in the output register, and the next request
// can be taken meanwhile.
// The rules_in_use register must be written only while the block is idle.
`default_nettype none

module first_match_access_rule_check_top #(
  parameter int unsigned MAX_RULES     = 16,
  parameter int unsigned CERT_TAG_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i,
  // Request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [3:0]  slot_i,
  input  wire logic [1:0]  source_kind_i,
  input  wire logic        is_v6_i,
  input  wire logic [63:0] addr_hi_i,
  input  wire logic [63:0] addr_lo_i,
  input  wire logic [7:0]  prefix_len_i,
  input  wire logic [1:0]  transport_i,
  input  wire logic [3:0]  caps_i,
  input  wire logic        force_ack_i,
  input  wire logic [15:0] cert_tag_i,
  input  wire logic [1:0]  req_flags_i,
  // Result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             allowed_o,
  output logic [4:0]       offender_count_o,
  output logic             offender_any_cert_o,
  output logic [3:0]       first_offender_slot_o
);
  import fmarc_pkg::*;

  localparam int unsigned IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_RULES + 1);

  state_e              state_q, state_d;
  logic [4:0]          rules_in_use_q;
  op_e                 op_q, op_d;
  req_t                req_q, req_d;
  logic [CERT_TAG_BITS-1:0] req_tag_q, req_tag_d;
  logic [CNT_W-1:0]    n_q, n_d;
  logic [CNT_W-1:0]    issue_idx_q, issue_idx_d;
  logic [CNT_W-1:0]    eval_idx_q, eval_idx_d;
  logic                rd_pending_q, rd_pending_d;
  logic                eval_last_q, eval_last_d;
  logic                res_allowed_q, res_allowed_d;
  logic [4:0]          res_count_q, res_count_d;
  logic                res_any_q, res_any_d;
  logic [3:0]          res_slot_q, res_slot_d;
  logic                out_valid_q, out_valid_d;
  logic                out_load;

  logic                in_accept;
  logic                wr_en;
  rule_t               wr_rule;
  logic [7:0]          plen_lim;
  logic [CERT_TAG_BITS-1:0] in_tag;
  logic                rd_en;
  rule_t               rd_rule;
  logic [CERT_TAG_BITS-1:0] rd_tag;
  verdict_t            verdict;
  logic [CNT_W-1:0]    n_in;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_tag = CERT_TAG_BITS'(32'(cert_tag_i));

  // Active rule count, capped at the table depth.
  assign n_in = (32'(rules_in_use_q) > MAX_RULES) ? CNT_W'(MAX_RULES) : CNT_W'(rules_in_use_q);

  // Rule record for a write request, prefix length saturated per family.
  always_comb begin
    plen_lim          = is_v6_i ? PLEN_MAX_V6 : PLEN_MAX_V4;
    wr_rule.hi        = addr_hi_i;
    wr_rule.lo        = addr_lo_i;
    wr_rule.kind      = src_e'(source_kind_i);
    wr_rule.v6        = is_v6_i;
    wr_rule.plen      = (prefix_len_i > plen_lim) ? plen_lim : prefix_len_i;
    wr_rule.trans     = transport_i;
    wr_rule.caps      = caps_i;
    wr_rule.force_ack = force_ack_i;
    wr_en = in_accept && (op_i == OP_WRITE) && (32'(slot_i) < MAX_RULES);
  end

  // Each table read is evaluated in the cycle after it is issued.
  assign rd_en = (state_q == ST_WALK) && (issue_idx_q < n_q);

  fmarc_rule_mem #(
    .DEPTH (MAX_RULES),
    .IDX_W (IDX_W),
    .TAG_W (CERT_TAG_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (IDX_W'(slot_i)),
    .wr_rule_i (wr_rule),
    .wr_tag_i  (in_tag),
    .rd_en_i   (rd_en),
    .rd_addr_i (issue_idx_q[IDX_W-1:0]),
    .rd_rule_o (rd_rule),
    .rd_tag_o  (rd_tag)
  );

  fmarc_rule_eval #(
    .TAG_W (CERT_TAG_BITS)
  ) u_eval (
    .rule_i     (rd_rule),
    .rule_tag_i (rd_tag),
    .req_i      (req_q),
    .req_tag_i  (req_tag_q),
    .verdict_o  (verdict)
  );

  // Next state, walk bookkeeping and result accumulation.
  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    req_d         = req_q;
    req_tag_d     = req_tag_q;
    n_d           = n_q;
    issue_idx_d   = issue_idx_q;
    eval_idx_d    = eval_idx_q;
    rd_pending_d  = 1'b0;
    eval_last_d   = eval_last_q;
    res_allowed_d = res_allowed_q;
    res_count_d   = res_count_q;
    res_any_d     = res_any_q;
    res_slot_d    = res_slot_q;
    out_load      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          op_d          = op_e'(op_i);
          req_d.hi      = addr_hi_i;
          req_d.lo      = addr_lo_i;
          req_d.v6      = is_v6_i;
          req_d.need    = caps_i;
          req_d.enc     = req_flags_i[0];
          req_d.ver     = req_flags_i[1];
          req_tag_d     = in_tag;
          n_d           = n_in;
          issue_idx_d   = '0;
          res_allowed_d = 1'b0;
          res_count_d   = '0;
          res_any_d     = 1'b0;
          res_slot_d    = '0;
          if (((op_i == OP_CHECK) || (op_i == OP_AUDIT)) && (n_in != '0)) begin
            state_d = ST_WALK;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_WALK: begin
        // Issue the next read.
        if (rd_en) begin
          issue_idx_d  = issue_idx_q + 1'b1;
          rd_pending_d = 1'b1;
          eval_idx_d   = issue_idx_q;
          eval_last_d  = (issue_idx_q == n_q - 1'b1);
        end
        // Evaluate the rule read last cycle.
        if (rd_pending_q) begin
          if (op_q == OP_CHECK) begin
            if (verdict.hit) begin
              res_allowed_d = verdict.grant;
              state_d       = ST_HOLD;
            end
          end else if (verdict.offend) begin
            if (res_count_q == '0) begin
              res_any_d  = verdict.any_cert;
              res_slot_d = 4'(eval_idx_q);
            end
            if (res_count_q < COUNT_SAT) begin
              res_count_d = res_count_q + 1'b1;
            end
          end
          if (eval_last_q) begin
            state_d = ST_HOLD;
          end
          if (state_d == ST_HOLD) begin
            rd_pending_d = 1'b0;
          end
        end
      end
      ST_HOLD: begin
        // Move the result out once the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      rules_in_use_q <= '0;
      rd_pending_q   <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      rd_pending_q <= rd_pending_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        rules_in_use_q <= cfg_wdata_i;
      end
    end
  end

  // Request, walk and result payload registers.
  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    req_q         <= req_d;
    req_tag_q     <= req_tag_d;
    n_q           <= n_d;
    issue_idx_q   <= issue_idx_d;
    eval_idx_q    <= eval_idx_d;
    eval_last_q   <= eval_last_d;
    res_allowed_q <= res_allowed_d;
    res_count_q   <= res_count_d;
    res_any_q     <= res_any_d;
    res_slot_q    <= res_slot_d;
    if (out_load) begin
      allowed_o             <= res_allowed_q;
      offender_count_o      <= res_count_q;
      offender_any_cert_o   <= res_any_q;
      first_offender_slot_o <= res_slot_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // An accepted request always leaves the idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q != ST_IDLE))
    else $error("accepted request did not start work");

  // A returning read always belongs to an active rule.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pending_q |-> (eval_idx_q < n_q))
    else $error("evaluated slot beyond active rule count");

  // The audit count never exceeds the number of active rules.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (32'(res_count_q) <= 32'(n_q)))
    else $error("audit count exceeds active rules");

  // A result only enters the output register when the previous one has gone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ----- bench/first_match_access_rule_check_top_test.sv -----
// Self-checking testbench for first_match_access_rule_check_top: rule writes, checks and audits.
// Predicts every answer with its own copy of the rule table; depends on fmarc_pkg and the RTL.
module first_match_access_rule_check_top_test;
  import fmarc_pkg::*;

  localparam int unsigned RULE_SLOTS      = 16;
  localparam int unsigned PHASES          = 9;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned IDLE_SETTLE     = 25;
  localparam int unsigned END_SETTLE      = 40;
  localparam int unsigned LONG_HOLD       = 300;
  localparam int unsigned WATCHDOG_LIMIT  = 5000;

  localparam logic [1:0] OP_IGNORED  = 2'd3;
  localparam logic [1:0] TR_RESERVED = 2'd3;
  localparam logic [1:0] FLAG_ENC    = 2'b01;
  localparam logic [1:0] FLAG_VER    = 2'b10;

  // One request as it travels on the input channel.
  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  slot;
    logic [1:0]  source_kind;
    logic        is_v6;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  prefix_len;
    logic [1:0]  transport;
    logic [3:0]  caps;
    logic        force_ack;
    logic [15:0] cert_tag;
    logic [1:0]  req_flags;
  } rule_request_t;

  // One answer on the result channel.
  typedef struct packed {
    logic       allowed;
    logic [4:0] offender_count;
    logic       offender_any_cert;
    logic [3:0] first_offender_slot;
  } acl_answer_t;

  // One stored rule of the shadow table.
  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [1:0]  kind;
    logic        v6;
    logic [7:0]  plen;
    logic [1:0]  trans;
    logic [3:0]  caps;
    logic        force_ack;
    logic [15:0] tag;
  } shadow_rule_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [4:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  op_i;
  logic [3:0]  slot_i;
  logic [1:0]  source_kind_i;
  logic        is_v6_i;
  logic [63:0] addr_hi_i;
  logic [63:0] addr_lo_i;
  logic [7:0]  prefix_len_i;
  logic [1:0]  transport_i;
  logic [3:0]  caps_i;
  logic        force_ack_i;
  logic [15:0] cert_tag_i;
  logic [1:0]  req_flags_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        allowed_o;
  logic [4:0]  offender_count_o;
  logic        offender_any_cert_o;
  logic [3:0]  first_offender_slot_o;

  int unsigned tx_gap_pct;
  int unsigned rx_stall_pct;
  bit          long_hold;

  first_match_access_rule_check_top dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .op_i                  (op_i),
    .slot_i                (slot_i),
    .source_kind_i         (source_kind_i),
    .is_v6_i               (is_v6_i),
    .addr_hi_i             (addr_hi_i),
    .addr_lo_i             (addr_lo_i),
    .prefix_len_i          (prefix_len_i),
    .transport_i           (transport_i),
    .caps_i                (caps_i),
    .force_ack_i           (force_ack_i),
    .cert_tag_i            (cert_tag_i),
    .req_flags_i           (req_flags_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .allowed_o             (allowed_o),
    .offender_count_o      (offender_count_o),
    .offender_any_cert_o   (offender_any_cert_o),
    .first_offender_slot_o (first_offender_slot_o)
  );

  // Mask with the leading n bits of a 64-bit word set.
  function automatic logic [63:0] prefix_mask(input logic [7:0] n);
    if (n == 8'd0) return '0;
    if (n >= HALF_BITS) return '1;
    return 64'hFFFF_FFFF_FFFF_FFFF << (8'd64 - n);
  endfunction

  // Shadow rule table, answer predictor and queue of predicted answers.
  class rule_verdict_scoreboard;
    shadow_rule_t rules [RULE_SLOTS];
    logic [4:0]   rules_in_use;
    acl_answer_t  pending_answers [$];
    int unsigned mismatches, orphans, reported, compared;
    int unsigned writes, checks, grants, audits, flagged_audits, ignored;

    function new();
      rules_in_use = '0;
    endfunction

    function int unsigned active_rules();
      return (rules_in_use > RULE_SLOTS) ? RULE_SLOTS : int'(rules_in_use);
    endfunction

    function bit source_matches(input shadow_rule_t r, input rule_request_t q);
      case (r.kind)
        SRC_PREFIX: begin
          if (r.v6 != q.is_v6) return 1'b0;
          if (((r.hi ^ q.addr_hi) & prefix_mask(r.plen)) != 64'd0) return 1'b0;
          if (!r.v6 || r.plen <= HALF_BITS) return 1'b1;
          return ((r.lo ^ q.addr_lo) & prefix_mask(r.plen - HALF_BITS)) == 64'd0;
        end
        SRC_LOOPBACK: begin
          if (q.is_v6) return q.addr_hi == 64'd0 && q.addr_lo == 64'd1;
          return q.addr_hi[63:56] == LOOPBACK_V4;
        end
        SRC_ANY_CERT: return q.req_flags[1];
        default: return q.req_flags[1] && q.cert_tag != 16'd0 && r.tag != 16'd0 &&
                        r.tag == q.cert_tag;
      endcase
    endfunction

    function bit rule_is_broad(input shadow_rule_t r);
      if (r.kind == SRC_ANY_CERT) return 1'b1;
      if (r.kind == SRC_PREFIX) return r.plen < (r.v6 ? WIDE_V6 : WIDE_V4);
      return 1'b0;
    endfunction

    // Applies one request to the shadow table and returns the answer it must give.
    function acl_answer_t predict_answer(input rule_request_t q);
      acl_answer_t  a;
      shadow_rule_t r;
      logic [7:0]   lim;
      logic [4:0]   cnt;
      int unsigned  i, n;
      bit           enc, found;
      a = '0;
      n = active_rules();
      enc = q.req_flags[0];
      case (q.op)
        OP_WRITE: begin
          lim = q.is_v6 ? PLEN_MAX_V6 : PLEN_MAX_V4;
          r.hi = q.addr_hi;
          r.lo = q.addr_lo;
          r.kind = q.source_kind;
          r.v6 = q.is_v6;
          r.plen = (q.prefix_len > lim) ? lim : q.prefix_len;
          r.trans = q.transport;
          r.caps = q.caps;
          r.force_ack = q.force_ack;
          r.tag = q.cert_tag;
          rules[q.slot] = r;
        end
        OP_CHECK: begin
          // The first rule whose transport and source both admit the request decides.
          found = 1'b0;
          for (i = 0; i < n && !found; i++) begin
            r = rules[i];
            if (!(r.trans == TR_PLAIN && enc) && !(r.trans == TR_ENC && !enc) &&
                source_matches(r, q)) begin
              a.allowed = |(r.caps & q.caps);
              found = 1'b1;
            end
          end
        end
        OP_AUDIT: begin
          cnt = '0;
          for (i = 0; i < n; i++) begin
            r = rules[i];
            if (r.caps[CAP_ADMIN_BIT] && !r.force_ack && rule_is_broad(r)) begin
              if (cnt == 5'd0) begin
                a.offender_any_cert = (r.kind == SRC_ANY_CERT);
                a.first_offender_slot = 4'(i);
              end
              if (cnt < COUNT_SAT) cnt++;
            end
          end
          a.offender_count = cnt;
        end
        default: ;
      endcase
      return a;
    endfunction

    function void note_request(input rule_request_t q);
      acl_answer_t a;
      a = predict_answer(q);
      pending_answers.push_back(a);
      case (q.op)
        OP_WRITE: writes++;
        OP_CHECK: begin
          checks++;
          if (a.allowed) grants++;
        end
        OP_AUDIT: begin
          audits++;
          if (a.offender_count != 5'd0) flagged_audits++;
        end
        default: ignored++;
      endcase
    endfunction

    function void check_answer(input acl_answer_t got);
      acl_answer_t want;
      if (pending_answers.size() == 0) begin
        orphans++;
        reported++;
        if (reported <= 10)
          $display("answer with no request pending: allowed %0b count %0d any_cert %0b slot %0d",
                   got.allowed, got.offender_count, got.offender_any_cert,
                   got.first_offender_slot);
        return;
      end
      want = pending_answers.pop_front();
      compared++;
      if (got.allowed !== want.allowed || got.offender_count !== want.offender_count ||
          got.offender_any_cert !== want.offender_any_cert ||
          got.first_offender_slot !== want.first_offender_slot) begin
        mismatches++;
        reported++;
        if (reported <= 10)
          $display("answer exp/act: allowed %0b/%0b count %0d/%0d any_cert %0b/%0b slot %0d/%0d",
                   want.allowed, got.allowed, want.offender_count, got.offender_count,
                   want.offender_any_cert, got.offender_any_cert,
                   want.first_offender_slot, got.first_offender_slot);
      end
    endfunction
  endclass

  rule_verdict_scoreboard sb;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Result side: random stalls, or one long hold-off when asked for.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold = 1'b0;
      end
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Compare every accepted answer against the oldest prediction.
  always @(posedge clk_i) begin : answer_monitor
    acl_answer_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.allowed = allowed_o;
      got.offender_count = offender_count_o;
      got.offender_any_cert = offender_any_cert_o;
      got.first_offender_slot = first_offender_slot_o;
      sb.check_answer(got);
    end
  end

  // Give up when neither channel moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("first_match_access_rule_check_top_test: FAIL");
    $finish;
  end

  // Request with every field random; the op is set by the caller.
  function automatic rule_request_t blank_request(input logic [1:0] op);
    rule_request_t q;
    q.op = op;
    q.slot = 4'($urandom_range(15));
    q.source_kind = 2'($urandom_range(3));
    q.is_v6 = 1'($urandom_range(1));
    q.addr_hi = {$urandom(), $urandom()};
    q.addr_lo = {$urandom(), $urandom()};
    q.prefix_len = 8'($urandom_range(255));
    q.transport = 2'($urandom_range(3));
    q.caps = 4'($urandom_range(15));
    q.force_ack = 1'($urandom_range(1));
    q.cert_tag = 16'($urandom_range(16'hFFFF));
    q.req_flags = 2'($urandom_range(3));
    return q;
  endfunction

  // Prefix lengths lean toward the edges of the matching and audit rules.
  function automatic logic [7:0] pick_plen(input logic v6);
    case ($urandom_range(9))
      0: return 8'd0;
      1: return v6 ? PLEN_MAX_V6 : PLEN_MAX_V4;
      2: return v6 ? WIDE_V6 : WIDE_V4;
      3: return v6 ? WIDE_V6 - 8'd1 : WIDE_V4 - 8'd1;
      4: return 8'($urandom_range(255));
      5: return v6 ? HALF_BITS : 8'd16;
      6: return v6 ? HALF_BITS + 8'd1 : 8'd31;
      default: return v6 ? 8'($urandom_range(128)) : 8'($urandom_range(32));
    endcase
  endfunction

  // A few tags recur so that named certificates actually meet.
  function automatic logic [15:0] pick_tag();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(1, 3));
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic rule_request_t random_rule_write();
    rule_request_t q;
    q = blank_request(OP_WRITE);
    q.prefix_len = pick_plen(q.is_v6);
    q.cert_tag = pick_tag();
    return q;
  endfunction

  // Most checks are aimed at an active rule so that the walk gets past the first slots.
  function automatic rule_request_t random_check();
    rule_request_t q;
    shadow_rule_t  r;
    int unsigned   n;
    q = blank_request(OP_CHECK);
    q.cert_tag = pick_tag();
    n = sb.active_rules();
    if (n > 0 && $urandom_range(99) < 65) begin
      r = sb.rules[$urandom_range(n - 1)];
      q.is_v6 = r.v6;
      q.addr_hi = r.hi ^ (q.addr_hi & ~prefix_mask(r.plen));
      if (r.v6 && r.plen > HALF_BITS)
        q.addr_lo = r.lo ^ (q.addr_lo & ~prefix_mask(r.plen - HALF_BITS));
      if (r.kind == SRC_LOOPBACK) begin
        if ($urandom_range(1)) begin
          q.is_v6 = 1'b1;
          q.addr_hi = 64'd0;
          q.addr_lo = 64'd1;
        end else begin
          q.is_v6 = 1'b0;
          q.addr_hi[63:56] = LOOPBACK_V4;
        end
      end
      if (r.trans == TR_PLAIN) q.req_flags[0] = 1'b0;
      if (r.trans == TR_ENC) q.req_flags[0] = 1'b1;
      if ((r.kind == SRC_ANY_CERT || r.kind == SRC_NAMED) && $urandom_range(9) != 0)
        q.req_flags[1] = 1'b1;
      if (r.kind == SRC_NAMED && $urandom_range(3) != 0) q.cert_tag = r.tag;
    end else if ($urandom_range(9) == 0) begin
      q.addr_hi[63:56] = LOOPBACK_V4;
    end
    return q;
  endfunction

  function automatic rule_request_t random_request();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 25) return random_rule_write();
    if (pick < 72) return random_check();
    if (pick < 96) return blank_request(OP_AUDIT);
    return blank_request(OP_IGNORED);
  endfunction

  function automatic rule_request_t fixed_rule(
    input logic [3:0] slot, input logic [1:0] kind, input logic v6,
    input logic [63:0] hi, input logic [63:0] lo, input logic [7:0] plen,
    input logic [1:0] trans, input logic [3:0] caps, input logic force_ack,
    input logic [15:0] tag);
    rule_request_t q;
    q = blank_request(OP_WRITE);
    q.slot = slot;
    q.source_kind = kind;
    q.is_v6 = v6;
    q.addr_hi = hi;
    q.addr_lo = lo;
    q.prefix_len = plen;
    q.transport = trans;
    q.caps = caps;
    q.force_ack = force_ack;
    q.cert_tag = tag;
    return q;
  endfunction

  function automatic rule_request_t fixed_check(
    input logic v6, input logic [63:0] hi, input logic [63:0] lo,
    input logic [3:0] need, input logic [1:0] flags, input logic [15:0] tag);
    rule_request_t q;
    q = blank_request(OP_CHECK);
    q.is_v6 = v6;
    q.addr_hi = hi;
    q.addr_lo = lo;
    q.caps = need;
    q.req_flags = flags;
    q.cert_tag = tag;
    return q;
  endfunction

  // Offer one request, with a random gap first, and hold it until it is taken.
  task automatic send_request(input rule_request_t q);
    if ($urandom_range(99) < tx_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_gap_pct);
    end
    op_i          <= q.op;
    slot_i        <= q.slot;
    source_kind_i <= q.source_kind;
    is_v6_i       <= q.is_v6;
    addr_hi_i     <= q.addr_hi;
    addr_lo_i     <= q.addr_lo;
    prefix_len_i  <= q.prefix_len;
    transport_i   <= q.transport;
    caps_i        <= q.caps;
    force_ack_i   <= q.force_ack;
    cert_tag_i    <= q.cert_tag;
    req_flags_i   <= q.req_flags;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(q);
  endtask

  // Stop offering and wait until every predicted answer has come back.
  task automatic drain_requests();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_answers.size() != 0);
  endtask

  // The rule count may only change while the block is idle.
  task automatic configure_rules(input logic [4:0] count);
    drain_requests();
    repeat (IDLE_SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    sb.rules_in_use = count;
    cfg_we_i <= 1'b0;
  endtask

  // Fill every slot with hand-picked rules, then probe the special cases.
  task automatic run_directed();
    // With no active rules nothing matches and nothing offends.
    send_request(fixed_check(1'b0, 64'h7F00_0001_0000_0000, 64'd0, 4'hF,
                             FLAG_ENC | FLAG_VER, 16'h0001));
    send_request(blank_request(OP_AUDIT));
    send_request(blank_request(OP_IGNORED));
    send_request(fixed_rule(4'd0, SRC_PREFIX, 1'b0, 64'h0A00_0000_FFFF_FFFF, '1, 8'd8,
                            TR_PLAIN, 4'h1, 1'b0, 16'h0000));
    send_request(fixed_rule(4'd1, SRC_LOOPBACK, 1'b0, '0, '0, 8'd0,
                            TR_ENC, 4'h2, 1'b0, 16'h0000));
    send_request(fixed_rule(4'd2, SRC_LOOPBACK, 1'b1, '0, '0, 8'd0,
                            TR_RESERVED, 4'h4, 1'b0, 16'h0000));
    send_request(fixed_rule(4'd3, SRC_ANY_CERT, 1'b0, '0, '0, 8'd0,
                            TR_ANY, 4'h8, 1'b0, 16'h0000));
    send_request(fixed_rule(4'd4, SRC_NAMED, 1'b1, '0, '0, 8'd0,
                            TR_ANY, 4'hF, 1'b0, 16'hFFFF));
    send_request(fixed_rule(4'd5, SRC_NAMED, 1'b0, '0, '0, 8'd0,
                            TR_ANY, 4'hF, 1'b0, 16'h0000));
    // Oversized prefixes saturate at the family's full length.
    send_request(fixed_rule(4'd6, SRC_PREFIX, 1'b1, '1, '1, 8'hFF,
                            TR_ANY, 4'h8, 1'b0, 16'h1234));
    send_request(fixed_rule(4'd7, SRC_PREFIX, 1'b0, 64'hFFFF_FFFF_0000_0000, '0, 8'd200,
                            TR_ANY, 4'hF, 1'b0, 16'h0000));
    // Either side of the wide-prefix limits for both families.
    send_request(fixed_rule(4'd8, SRC_PREFIX, 1'b0, 64'hC0A8_0000_0000_0000, '0, 8'd23,
                            TR_ANY, 4'h8, 1'b0, 16'h0000));
    send_request(fixed_rule(4'd9, SRC_PREFIX, 1'b0, 64'hC0A9_0000_0000_0000, '0, 8'd24,
                            TR_ANY, 4'hC, 1'b0, 16'h0000));
    send_request(fixed_rule(4'd10, SRC_PREFIX, 1'b1, 64'h2001_0DB8_0000_0000, '0, 8'd119,
                            TR_ENC, 4'h8, 1'b0, 16'h0000));
    send_request(fixed_rule(4'd11, SRC_PREFIX, 1'b1, 64'h2001_0DB8_0000_0000, '0, 8'd120,
                            TR_ANY, 4'h8, 1'b1, 16'h0000));
    send_request(fixed_rule(4'd12, SRC_PREFIX, 1'b1, 64'hFE80_0000_0000_0000,
                            64'h8000_0000_0000_0000, 8'd65, TR_PLAIN, 4'h3, 1'b0, 16'h0000));
    send_request(fixed_rule(4'd13, SRC_PREFIX, 1'b0, '0, '0, 8'd0,
                            TR_ANY, 4'h0, 1'b0, 16'h0000));
    send_request(fixed_rule(4'd14, SRC_PREFIX, 1'b1, '0, '0, 8'd0,
                            TR_ANY, 4'hF, 1'b1, 16'h0000));
    send_request(fixed_rule(4'd15, SRC_ANY_CERT, 1'b1, '0, '0, 8'd0,
                            TR_RESERVED, 4'h8, 1'b1, 16'hFFFF));
    configure_rules(5'd16);
    send_request(fixed_check(1'b0, 64'h0A01_0203_0000_0000, 64'd0, 4'h1, 2'b00, 16'h0000));
    send_request(fixed_check(1'b0, 64'h0A01_0203_0000_0000, 64'd0, 4'h1, FLAG_ENC, 16'h0000));
    send_request(fixed_check(1'b0, 64'h7F00_0001_0000_0000, 64'd0, 4'h2, FLAG_ENC, 16'h0000));
    send_request(fixed_check(1'b1, 64'd0, 64'd1, 4'h4, 2'b00, 16'h0000));
    send_request(fixed_check(1'b1, 64'h2001_0DB8_0000_0000, 64'd5, 4'h8,
                             FLAG_ENC | FLAG_VER, 16'hFFFF));
    send_request(blank_request(OP_AUDIT));
  endtask

  // Main sequence: reset, directed requests, then random phases over several rule counts.
  initial begin : stimulus
    logic [4:0]  count_plan [PHASES];
    int unsigned phase, k;
    count_plan = '{5'd31, 5'd1, 5'd0, 5'd16, 5'd9, 5'd17, 5'd4, 5'd16, 5'd12};
    sb = new();
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    op_i          <= '0;
    slot_i        <= '0;
    source_kind_i <= '0;
    is_v6_i       <= 1'b0;
    addr_hi_i     <= '0;
    addr_lo_i     <= '0;
    prefix_len_i  <= '0;
    transport_i   <= '0;
    caps_i        <= '0;
    force_ack_i   <= 1'b0;
    cert_tag_i    <= '0;
    req_flags_i   <= '0;
    tx_gap_pct    = 20;
    rx_stall_pct  = 73;
    long_hold     = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();

    for (phase = 0; phase < PHASES; phase++) begin
      configure_rules(count_plan[phase]);
      case (phase % 3)
        0: begin
          tx_gap_pct = 20;
          rx_stall_pct = 73;
        end
        1: begin
          tx_gap_pct = 73;
          rx_stall_pct = 20;
        end
        default: begin
          tx_gap_pct = 0;
          rx_stall_pct = 0;
        end
      endcase
      // Let the block back up behind a stalled result side.
      if (phase == 3 || phase == 5) long_hold = 1'b1;
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k == ITEMS_PER_PHASE / 2 && phase % 2 == 0) drain_requests();
        send_request(random_request());
      end
    end

    drain_requests();
    repeat (END_SETTLE) @(posedge clk_i);
    $display("Covered %0d rule writes, %0d checks (%0d allowed), %0d audits (%0d flagged), %0d other",
             sb.writes, sb.checks, sb.grants, sb.audits, sb.flagged_audits, sb.ignored);
    $display("%0d rule-count settings; %0d answers compared, %0d wrong, %0d unexpected, %0d missing",
             PHASES + 1, sb.compared, sb.mismatches, sb.orphans, sb.pending_answers.size());
    if (sb.mismatches == 0 && sb.orphans == 0 && sb.pending_answers.size() == 0)
      $display("first_match_access_rule_check_top_test: PASS");
    else
      $display("first_match_access_rule_check_top_test: FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/fmarc_pkg.sv
rtl/fmarc_rule_mem.sv
rtl/fmarc_rule_eval.sv
rtl/first_match_access_rule_check_top.sv
bench/first_match_access_rule_check_top_test.sv
